@@ src/hsl_pkg.sv @@
// Shared types, constants and sector tables for the HSL to RGB converter.
`default_nettype none

package hsl_pkg;

	localparam int HueW    = 9;
	localparam int ChanW   = 8;
	localparam int NumChan = 3;

	// Hue angle limits and sector boundaries, in degrees
	localparam logic [HueW-1:0] HUE_MAX = 9'd359;
	localparam logic [HueW-1:0] HUE_60  = 9'd60;
	localparam logic [HueW-1:0] HUE_120 = 9'd120;
	localparam logic [HueW-1:0] HUE_180 = 9'd180;
	localparam logic [HueW-1:0] HUE_240 = 9'd240;
	localparam logic [HueW-1:0] HUE_300 = 9'd300;

	// Channel offset is l + floor(cw * j / 15300), j in [-30, 30]
	localparam int              ProdW     = 21;
	localparam logic [4:0]      HALF_SPAN = 5'd30;
	localparam logic [ProdW-1:0] CEIL_BIAS = 21'd15299;

	// 2^35 / 15300 rounded up; exact floor for numerators below 2^21
	localparam int               RecipW     = 22;
	localparam int               RecipShift = 35;
	localparam logic [RecipW-1:0] RECIP     = 22'd2245735;
	localparam int               QuotW      = 8;

	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYA,
		SEC_CYA_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} sector_t;

	typedef enum logic [1:0] {
		KIND_CHROMA,
		KIND_SECOND,
		KIND_ZERO
	} chan_kind_t;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [HueW-1:0]  hue_degrees;
		logic [ChanW-1:0] saturation;
		logic [ChanW-1:0] lightness;
	} hsl_pix_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} rgb_pix_t;

	// Which component lands on a channel in a given hue sector
	function automatic chan_kind_t chan_kind(sector_t sec, logic [1:0] ch);
		chan_kind_t k;
		k = KIND_ZERO;
		case (sec)
			SEC_RED_YEL: k = (ch == CH_RED) ? KIND_CHROMA :
				(ch == CH_GREEN) ? KIND_SECOND : KIND_ZERO;
			SEC_YEL_GRN: k = (ch == CH_RED) ? KIND_SECOND :
				(ch == CH_GREEN) ? KIND_CHROMA : KIND_ZERO;
			SEC_GRN_CYA: k = (ch == CH_RED) ? KIND_ZERO :
				(ch == CH_GREEN) ? KIND_CHROMA : KIND_SECOND;
			SEC_CYA_BLU: k = (ch == CH_RED) ? KIND_ZERO :
				(ch == CH_GREEN) ? KIND_SECOND : KIND_CHROMA;
			SEC_BLU_MAG: k = (ch == CH_RED) ? KIND_SECOND :
				(ch == CH_GREEN) ? KIND_ZERO : KIND_CHROMA;
			default: k = (ch == CH_RED) ? KIND_CHROMA :
				(ch == CH_GREEN) ? KIND_ZERO : KIND_SECOND;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

@@ src/hsl_in_if.sv @@
// Input pixel channel: valid/ready handshake carrying hue, saturation, lightness.
`default_nettype none

interface hsl_in_if
	import hsl_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [HueW-1:0]  hue_degrees;
	logic [ChanW-1:0] saturation;
	logic [ChanW-1:0] lightness;

	modport source (output valid, hue_degrees, saturation, lightness, input ready);
	modport sink   (input valid, hue_degrees, saturation, lightness, output ready);
endinterface

`default_nettype wire

@@ src/hsl_out_if.sv @@
// Output pixel channel: valid/ready handshake carrying red, green, blue.
`default_nettype none

interface hsl_out_if
	import hsl_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

@@ src/hsl_to_rgb_converter.sv @@
// An accepted request passes through stages 1 to 6 to its result on pix_out.
// Throughput: one pixel per clock while pix_out.ready is high; six register stages, the longest holding
// a 21 x 22 bit reciprocal multiply.
// A stalled stage holds; empty stages upstream still fill, so input is taken
// while a result waits. arst_n clears the stage valid bits; data is not reset.
`default_nettype none

module hsl_to_rgb_converter
	import hsl_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	hsl_in_if.sink       pix_in,
	hsl_out_if.source    pix_out
);

	localparam int NumStages = 6;

	logic [NumStages:1] vld;
	logic [NumStages:1] en;

	// Stage 1: clamp hue, find sector, distance from the middle of its 120 degree span, and weight
	sector_t          sec_s1;
	logic [5:0]       dh_s1;
	logic [ChanW-1:0] w_s1;
	logic [ChanW-1:0] sat_s1;
	logic [ChanW-1:0] lit_s1;

	// Stage 2: chroma numerator
	sector_t          sec_s2;
	logic [5:0]       dh_s2;
	logic [15:0]      cw_s2;
	logic [ChanW-1:0] lit_s2;

	// Stage 3: chroma and secondary magnitudes
	sector_t          sec_s3;
	logic [ProdW-1:0] ac_s3;
	logic [ProdW-1:0] ax_s3;
	logic             xneg_s3;
	logic [ChanW-1:0] lit_s3;

	// Stage 4: per channel numerator with ceiling bias for negatives
	logic [ProdW-1:0] num_s4 [NumChan];
	logic             neg_s4 [NumChan];
	logic [ChanW-1:0] lit_s4;

	// Stage 5: quotient
	logic [QuotW-1:0] quo_s5 [NumChan];
	logic             neg_s5 [NumChan];
	logic [ChanW-1:0] lit_s5;

	// Stage 6: output register
	logic [ChanW-1:0] chan_s6 [NumChan];

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en[NumStages] = !vld[NumStages] || pix_out.ready;
		for (int i = NumStages - 1; i >= 1; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	assign pix_in.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1]) begin
				vld[1] <= pix_in.valid;
			end
			for (int i = 2; i <= NumStages; i++) begin
				if (en[i]) begin
					vld[i] <= vld[i-1];
				end
			end
		end
	end

	// ---------------- stage 1 ----------------
	logic [HueW-1:0] hue_c;
	logic [HueW-1:0] hue_base;
	logic [6:0]      hue_mod;
	sector_t         sec_c;
	logic [HueW-1:0] l2;

	always_comb begin
		hue_c = (pix_in.hue_degrees > HUE_MAX) ? HUE_MAX : pix_in.hue_degrees;
		if (hue_c >= HUE_300) begin
			sec_c = SEC_MAG_RED;
		end else if (hue_c >= HUE_240) begin
			sec_c = SEC_BLU_MAG;
		end else if (hue_c >= HUE_180) begin
			sec_c = SEC_CYA_BLU;
		end else if (hue_c >= HUE_120) begin
			sec_c = SEC_GRN_CYA;
		end else if (hue_c >= HUE_60) begin
			sec_c = SEC_YEL_GRN;
		end else begin
			sec_c = SEC_RED_YEL;
		end
		hue_base = (hue_c >= HUE_240) ? HUE_240 : (hue_c >= HUE_120) ? HUE_120 : '0;
		hue_mod  = 7'(hue_c - hue_base);
		l2       = {1'b0, pix_in.lightness} << 1;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sec_s1 <= sec_c;
			dh_s1  <= (hue_mod >= 7'(HUE_60)) ? 6'(hue_mod - 7'(HUE_60))
			                                  : 6'(7'(HUE_60) - hue_mod);
			// 255 * (1 - |2L - 1|)
			w_s1   <= pix_in.lightness[ChanW-1] ? ChanW'(9'd510 - l2) : ChanW'(l2);
			sat_s1 <= pix_in.saturation;
			lit_s1 <= pix_in.lightness;
		end
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk) begin
		if (en[2]) begin
			sec_s2 <= sec_s1;
			dh_s2  <= dh_s1;
			cw_s2  <= 16'(w_s1 * sat_s1);
			lit_s2 <= lit_s1;
		end
	end

	// ---------------- stage 3 ----------------
	logic       xneg_c;
	logic [4:0] xmag_c;

	always_comb begin
		xneg_c = dh_s2 > 6'(HALF_SPAN);
		xmag_c = xneg_c ? 5'(dh_s2 - 6'(HALF_SPAN)) : 5'(6'(HALF_SPAN) - dh_s2);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			sec_s3  <= sec_s2;
			ac_s3   <= ProdW'(cw_s2 * HALF_SPAN);
			ax_s3   <= ProdW'(cw_s2 * xmag_c);
			xneg_s3 <= xneg_c;
			lit_s3  <= lit_s2;
		end
	end

	// ---------------- stage 4 ----------------
	logic [ProdW-1:0] mag_c [NumChan];
	logic             neg_c [NumChan];

	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			case (chan_kind(sec_s3, 2'(c)))
				KIND_CHROMA: begin
					mag_c[c] = ac_s3;
					neg_c[c] = 1'b0;
				end
				KIND_SECOND: begin
					mag_c[c] = ax_s3;
					neg_c[c] = xneg_s3;
				end
				default: begin
					mag_c[c] = ac_s3;
					neg_c[c] = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int c = 0; c < NumChan; c++) begin
				// floor of a negative quotient is minus the ceiling of its magnitude
				num_s4[c] <= mag_c[c] + (neg_c[c] ? CEIL_BIAS : '0);
				neg_s4[c] <= neg_c[c];
			end
			lit_s4 <= lit_s3;
		end
	end

	// ---------------- stage 5 ----------------
	localparam int MulW = ProdW + RecipW;

	logic [MulW-1:0] mul_c [NumChan];

	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			mul_c[c] = MulW'(num_s4[c]) * MulW'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int c = 0; c < NumChan; c++) begin
				quo_s5[c] <= mul_c[c][RecipShift +: QuotW];
				neg_s5[c] <= neg_s4[c];
			end
			lit_s5 <= lit_s4;
		end
	end

	// ---------------- stage 6 ----------------
	localparam int SumW = ChanW + 3;

	logic signed [SumW-1:0] sum_c [NumChan];

	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			sum_c[c] = neg_s5[c] ? $signed(SumW'(lit_s5) - SumW'(quo_s5[c]))
			                     : $signed(SumW'(lit_s5) + SumW'(quo_s5[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int c = 0; c < NumChan; c++) begin
				if (sum_c[c] < 0) begin
					chan_s6[c] <= '0;
				end else if (sum_c[c] > $signed(SumW'({ChanW{1'b1}}))) begin
					chan_s6[c] <= '1;
				end else begin
					chan_s6[c] <= sum_c[c][ChanW-1:0];
				end
			end
		end
	end

	assign pix_out.valid = vld[NumStages];
	assign pix_out.red   = chan_s6[CH_RED];
	assign pix_out.green = chan_s6[CH_GREEN];
	assign pix_out.blue  = chan_s6[CH_BLUE];

	// ---------------- assertions ----------------
	a_ready_when_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.ready |-> pix_in.ready)
		else $error("input stalled while output side is ready");

	a_ready_when_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_out.valid |-> pix_in.ready)
		else $error("input stalled with an empty output stage");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready) ##1 pix_out.ready ##1 pix_out.ready
		##1 pix_out.ready ##1 pix_out.ready ##1 pix_out.ready |=> pix_out.valid)
		else $error("request did not reach the output in six cycles");

endmodule

`default_nettype wire
